// ----- hdl/scd_pkg.sv -----
// Shared constants for the stereo chorus delay: register map, widths and sine coefficients.
`default_nettype none
package scd_pkg;

  // Configuration register map
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_DELAY_DEPTH = 2'd0;
  localparam cfg_idx_t CFG_PHASE_STEP  = 2'd1;
  localparam cfg_idx_t CFG_DRY_LEVEL   = 2'd2;
  localparam cfg_idx_t CFG_WET_LEVEL   = 2'd3;

  // Register widths
  localparam int DEPTH_W = 20;
  localparam int STEP_W  = 31;
  localparam int LEVEL_W = 16;
  localparam int PHASE_W = 32;

  // Register reset values
  localparam logic [DEPTH_W-1:0] DEPTH_RST = 20'd22579;
  localparam logic [STEP_W-1:0]  STEP_RST  = 31'd48695;
  localparam logic [LEVEL_W-1:0] DRY_RST   = 16'd32768;
  localparam logic [LEVEL_W-1:0] WET_RST   = 16'd32768;

  // LFO value is Q15; delay carries 8 fraction bits
  localparam int SINE_W = 16;
  localparam int FRAC_W = 8;

  typedef logic signed [SINE_W-1:0] sine_t;

  // Odd polynomial coefficients of the quarter-wave sine, Q30
  localparam longint unsigned C_A1  = 64'd1686629713;
  localparam longint unsigned C_A3  = 64'd693598669;
  localparam longint unsigned C_A5  = 64'd85569306;
  localparam longint unsigned C_A7  = 64'd5026996;
  localparam longint unsigned C_A9  = 64'd172273;
  localparam longint unsigned C_A11 = 64'd3864;

endpackage
`default_nettype wire

// ----- hdl/scd_sine_rom.sv -----
// LFO sine table: constant ROM built at elaboration, registered read.
`default_nettype none
module scd_sine_rom #(
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic                          clk,
  input  wire logic [$clog2(SINE_TABLE_SIZE)-1:0] phase_idx,
  output scd_pkg::sine_t                     sine_val
);

  localparam int KW = $clog2(SINE_TABLE_SIZE);

  typedef scd_pkg::sine_t lut_t [SINE_TABLE_SIZE];

  // One table entry from the quarter-wave polynomial, mirrored by quadrant
  function automatic scd_pkg::sine_t sine_entry(input longint unsigned k);
    longint unsigned w;
    longint unsigned quad;
    longint unsigned rem;
    longint unsigned r;
    longint unsigned t;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned v;
    longint unsigned mag;
    w    = (k % SINE_TABLE_SIZE) * 64'd4;
    quad = w / SINE_TABLE_SIZE;
    rem  = w % SINE_TABLE_SIZE;
    r    = quad[0] ? (SINE_TABLE_SIZE - rem) : rem;
    t    = (r << 30) / SINE_TABLE_SIZE;
    t2   = (t * t) >> 30;
    p    = scd_pkg::C_A11;
    p    = scd_pkg::C_A9 - ((p * t2) >> 30);
    p    = scd_pkg::C_A7 - ((p * t2) >> 30);
    p    = scd_pkg::C_A5 - ((p * t2) >> 30);
    p    = scd_pkg::C_A3 - ((p * t2) >> 30);
    p    = scd_pkg::C_A1 - ((p * t2) >> 30);
    v    = (p * t) >> 30;
    mag  = (v * 64'd32767 + (64'd1 << 29)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    if (quad >= 64'd2) begin
      return -$signed(scd_pkg::SINE_W'(mag));
    end
    return $signed(scd_pkg::SINE_W'(mag));
  endfunction

  function automatic lut_t build_lut();
    lut_t tab;
    for (int i = 0; i < SINE_TABLE_SIZE; i++) begin
      tab[i] = sine_entry(longint'(i));
    end
    return tab;
  endfunction

  localparam lut_t SINE_LUT = build_lut();

  scd_pkg::sine_t sine_r;

  // Registered table read
  always_ff @(posedge clk) begin
    sine_r <= SINE_LUT[phase_idx[KW-1:0]];
  end

  assign sine_val = sine_r;

endmodule
`default_nettype wire

// ----- hdl/stereo_chorus_delay_core.sv -----
// Stereo chorus core: LFO-modulated delay lines with dry/wet mix and saturation.
//
// Usage:
//   in_*  : one stereo frame per item, left sample in the low half of tdata.
//   out_* : one mixed, saturated stereo frame per input item, same packing.
//   cfg_* : write-only registers (depth, phase step, dry and wet gains),
//           written only while no frame is in flight (by the user; not enforced).
// Timing: a sequencer walks each frame through LFO table read, delay
//   multiply, modulo reduction, address build, dual-port history read,
//   interpolation and mix, one step per cycle; only the last step can stall.
//   A new frame is taken only once the last result is loaded, so frames
//   never overlap in the step chain through the history memories.
// Reset: configuration registers return to their defaults, the write
//   pointer and LFO phase to zero. The history memories are not swept: a
//   fill flag and the write pointer mark entries not yet written, which
//   read as zero, so the block takes frames as soon as reset is released.
// Stall: a finished frame waits in the output register; the sequencer holds
//   in its last step until that register is free, and input ready stays low.
`default_nettype none
module stereo_chorus_delay_core #(
  parameter int DELAY_DEPTH     = 4096,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int SINE_TABLE_SIZE = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // Input frames
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  input  wire logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    in_tdata,   // left_in, right_in
  // Result frames
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]         out_tdata,  // left_out, right_out
  // Configuration writes
  input  wire logic                                   cfg_we,
  input  wire logic [scd_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  wire logic [scd_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TDW  = ((2*SW+7)/8)*8;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int DW   = AW + 1;
  localparam int KW   = $clog2(SINE_TABLE_SIZE);
  localparam int KPW  = scd_pkg::PHASE_W + KW;
  localparam int DPW  = scd_pkg::DEPTH_W + scd_pkg::SINE_W;
  localparam int IW   = scd_pkg::DEPTH_W - scd_pkg::FRAC_W;  // integer delay bits
  localparam int WW   = SW + 10;                              // interpolated width
  localparam int ACW  = SW + 28;                              // mix accumulator width
  localparam int RS   = 24;
  localparam int QW   = 8;
  localparam int RMW  = 18;

  localparam logic [31:0]  RECIP   = 32'((64'd1 << RS) / DELAY_DEPTH);
  localparam logic [DW-1:0] DEPTH_D = DW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DELAY_DEPTH - 1);
  localparam logic signed [ACW-1:0] SAT_HI  = ACW'((64'sd1 <<< (SW-1)) - 64'sd1);
  localparam logic signed [ACW-1:0] SAT_LO  = -SAT_HI - ACW'(1);
  localparam logic signed [ACW-1:0] RND     = ACW'(64'sd1 <<< 22);

  // Sequencer steps
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ROM  = 4'd1;
  localparam logic [3:0] S_DLY  = 4'd2;
  localparam logic [3:0] S_QUO  = 4'd3;
  localparam logic [3:0] S_REM  = 4'd4;
  localparam logic [3:0] S_ADDR = 4'd5;
  localparam logic [3:0] S_OLD  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_INT  = 4'd8;
  localparam logic [3:0] S_WET  = 4'd9;
  localparam logic [3:0] S_MIX  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // Control state
  logic [3:0]                   state_r, state_nxt;
  logic [AW-1:0]                wp_r;
  logic                         full_r;
  logic [scd_pkg::PHASE_W-1:0]  phase_r;
  logic                         out_tvalid_r;

  // Configuration registers
  logic [scd_pkg::DEPTH_W-1:0]  depth_r;
  logic [scd_pkg::STEP_W-1:0]   step_r;
  logic [scd_pkg::LEVEL_W-1:0]  dry_r;
  logic [scd_pkg::LEVEL_W-1:0]  wetlvl_r;

  // Payload pipeline
  logic signed [SW-1:0]         x_l_r, x_r_r;
  logic [KPW-1:0]               kprod_r;
  scd_pkg::sine_t               sine;
  logic [DPW-1:0]               dprod_r;
  logic [QW-1:0]                q_r;
  logic [AW-1:0]                di_r;
  logic [AW-1:0]                rd_r, rd_old_r;
  logic                         v0_r, v1_r;
  logic signed [SW-1:0]         l_q0_r, l_q1_r, r_q0_r, r_q1_r;
  logic signed [WW-1:0]         pa_l_r, pb_l_r, pa_r_r, pb_r_r;
  logic signed [WW-1:0]         wet_l_r, wet_r_r;
  logic signed [ACW-1:0]        md_l_r, mw_l_r, md_r_r, mw_r_r;
  logic [TDW-1:0]               out_tdata_r;

  // History memories
  logic signed [SW-1:0]         left_mem  [DELAY_DEPTH];
  logic signed [SW-1:0]         right_mem [DELAY_DEPTH];

  // Combinational helpers
  logic                         in_acc;
  logic                         out_load;
  logic [IW-1:0]                di_raw;
  logic [scd_pkg::FRAC_W-1:0]   frac;
  logic [scd_pkg::SINE_W-1:0]   sine_off;
  logic [31:0]                  qprod;
  logic [RMW-1:0]               rem_raw, rem_fix;
  logic [DW-1:0]                rd_calc;
  logic [scd_pkg::FRAC_W:0]     nfrac;
  logic signed [SW-1:0]         h0_l, h1_l, h0_r, h1_r;
  logic [SW-1:0]                y_l, y_r;

  // Round to nearest by floor, then clamp to the sample range
  function automatic logic [SW-1:0] round_sat(input logic signed [ACW-1:0] md,
                                              input logic signed [ACW-1:0] mw);
    logic signed [ACW-1:0] acc;
    logic signed [ACW-1:0] y;
    acc = (md <<< 8) + mw + RND;
    y   = acc >>> 23;
    if (y > SAT_HI) begin
      y = SAT_HI;
    end else if (y < SAT_LO) begin
      y = SAT_LO;
    end
    return y[SW-1:0];
  endfunction

  assign in_acc   = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  // LFO table
  scd_sine_rom #(
    .SINE_TABLE_SIZE(SINE_TABLE_SIZE)
  ) u_sine_rom (
    .clk      (clk),
    .phase_idx(kprod_r[KPW-1:scd_pkg::PHASE_W]),
    .sine_val (sine)
  );

  // Delay arithmetic
  always_comb begin
    di_raw   = dprod_r[DPW-1 -: IW];
    frac     = dprod_r[DPW-IW-1 -: scd_pkg::FRAC_W];
    sine_off = {~sine[scd_pkg::SINE_W-1], sine[scd_pkg::SINE_W-2:0]};
    qprod    = 32'(di_raw) * RECIP;
    rem_raw  = RMW'(di_raw) - RMW'(q_r) * RMW'(DELAY_DEPTH);
    rem_fix  = (rem_raw >= RMW'(DELAY_DEPTH)) ? rem_raw - RMW'(DELAY_DEPTH) : rem_raw;
    if (DW'(wp_r) >= DW'(di_r)) begin
      rd_calc = DW'(wp_r) - DW'(di_r);
    end else begin
      rd_calc = DW'(wp_r) + DEPTH_D - DW'(di_r);
    end
    nfrac = (scd_pkg::FRAC_W+1)'(256) - {1'b0, frac};
    h0_l  = v0_r ? l_q0_r : '0;
    h1_l  = v1_r ? l_q1_r : '0;
    h0_r  = v0_r ? r_q0_r : '0;
    h1_r  = v1_r ? r_q1_r : '0;
    y_l   = round_sat(md_l_r, mw_l_r);
    y_r   = round_sat(md_r_r, mw_r_r);
  end

  // Step sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) begin
        state_nxt = S_ROM;
      end
      S_ROM:   state_nxt = S_DLY;
      S_DLY:   state_nxt = S_QUO;
      S_QUO:   state_nxt = S_REM;
      S_REM:   state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_OLD;
      S_OLD:   state_nxt = S_RD;
      S_RD:    state_nxt = S_INT;
      S_INT:   state_nxt = S_WET;
      S_WET:   state_nxt = S_MIX;
      S_MIX:   state_nxt = S_OUT;
      S_OUT:   if (out_load) begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wp_r         <= '0;
      full_r       <= 1'b0;
      phase_r      <= '0;
      out_tvalid_r <= 1'b0;
      depth_r      <= scd_pkg::DEPTH_RST;
      step_r       <= scd_pkg::STEP_RST;
      dry_r        <= scd_pkg::DRY_RST;
      wetlvl_r     <= scd_pkg::WET_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          scd_pkg::CFG_DELAY_DEPTH: depth_r  <= cfg_wdata[scd_pkg::DEPTH_W-1:0];
          scd_pkg::CFG_PHASE_STEP:  step_r   <= cfg_wdata[scd_pkg::STEP_W-1:0];
          scd_pkg::CFG_DRY_LEVEL:   dry_r    <= cfg_wdata[scd_pkg::LEVEL_W-1:0];
          scd_pkg::CFG_WET_LEVEL:   wetlvl_r <= cfg_wdata[scd_pkg::LEVEL_W-1:0];
          default: ;
        endcase
      end
      // Load a new result, or drop a taken one
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        phase_r      <= phase_r + scd_pkg::PHASE_W'(step_r);
        if (wp_r == LAST_A) begin
          wp_r   <= '0;
          full_r <= 1'b1;
        end else begin
          wp_r <= wp_r + AW'(1);
        end
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload steps
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_l_r   <= $signed(in_tdata[SW-1:0]);
      x_r_r   <= $signed(in_tdata[2*SW-1:SW]);
      kprod_r <= KPW'(phase_r) * KPW'(SINE_TABLE_SIZE);
    end
    if (state_r == S_DLY) begin
      dprod_r <= DPW'(depth_r) * DPW'(sine_off);
    end
    if (state_r == S_QUO) begin
      q_r <= qprod[RS +: QW];
    end
    if (state_r == S_REM) begin
      di_r <= AW'(rem_fix);
    end
    if (state_r == S_ADDR) begin
      rd_r <= AW'(rd_calc);
    end
    if (state_r == S_OLD) begin
      rd_old_r <= (rd_r == '0) ? LAST_A : rd_r - AW'(1);
    end
    // Unwritten entries read as zero
    if (state_r == S_RD) begin
      v0_r <= full_r || (rd_r <= wp_r);
      v1_r <= full_r || (rd_old_r <= wp_r);
    end
    if (state_r == S_INT) begin
      pa_l_r <= WW'($signed({1'b0, nfrac})) * WW'(h0_l);
      pb_l_r <= WW'($signed({2'b00, frac})) * WW'(h1_l);
      pa_r_r <= WW'($signed({1'b0, nfrac})) * WW'(h0_r);
      pb_r_r <= WW'($signed({2'b00, frac})) * WW'(h1_r);
    end
    if (state_r == S_WET) begin
      wet_l_r <= pa_l_r + pb_l_r;
      wet_r_r <= pa_r_r + pb_r_r;
    end
    if (state_r == S_MIX) begin
      md_l_r <= ACW'($signed({1'b0, dry_r})) * ACW'(x_l_r);
      md_r_r <= ACW'($signed({1'b0, dry_r})) * ACW'(x_r_r);
      mw_l_r <= ACW'($signed({1'b0, wetlvl_r})) * ACW'(wet_l_r);
      mw_r_r <= ACW'($signed({1'b0, wetlvl_r})) * ACW'(wet_r_r);
    end
    if (out_load) begin
      out_tdata_r <= TDW'({y_r, y_l});
    end
  end

  // History memories: write the new frame on accept, read both neighbors
  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_mem[wp_r] <= $signed(in_tdata[SW-1:0]);
    end
    l_q0_r <= left_mem[rd_r];
    l_q1_r <= left_mem[rd_old_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      right_mem[wp_r] <= $signed(in_tdata[2*SW-1:SW]);
    end
    r_q0_r <= right_mem[rd_r];
    r_q1_r <= right_mem[rd_old_r];
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Once every entry is written the fill flag never clears
  a_full_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("fill flag cleared");

  // Write pointer stays inside the memory
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    DW'(wp_r) < DEPTH_D)
    else $error("write pointer out of range");

  // Read addresses stay inside the memory when the read is issued
  a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (DW'(rd_r) < DEPTH_D && DW'(rd_old_r) < DEPTH_D))
    else $error("read address out of range");

  // A stalled result keeps the sequencer in its last step
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_tvalid_r && !out_tready) |=> (state_r == S_OUT))
    else $error("result step left while output blocked");

endmodule
`default_nettype wire
